>>> design/bltsp_pkg.sv
package bltsp_pkg;

  // Frame limits and pixel width.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIXEL_BITS = 32;

  // Derived widths.
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WDIM_W     = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W     = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 2);
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int COUNT_W    = 21;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Reset values of the frame size registers, already clamped to the limits.
  localparam int WIDTH_RST  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int HEIGHT_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SUBPASS = 2'd2;

  // Queue geometry, shared by the token queue and the result queue.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Thinning templates. Mask bits from bit 0 up: top-left, left, bottom-left,
  // bottom, bottom-right, right, top-right, top.
  localparam logic [7:0] TMPL_ON [8] = '{
    8'd40, 8'd10, 8'd130, 8'd160, 8'd42, 8'd138, 8'd162, 8'd168
  };
  localparam logic [7:0] TMPL_OFF [8] = '{
    8'd131, 8'd224, 8'd56, 8'd14, 8'd128, 8'd32, 8'd8, 8'd2
  };

  typedef struct packed {
    logic               op;
    logic signed [31:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]   pixel_out;
    logic                 was_deleted;
    logic                 frame_last;
    logic [COUNT_W-1:0]   deletion_count;
  } out_item_t;

  // One classified stream word, handed from the front end to the back end.
  typedef struct packed {
    logic [PIXEL_BITS-1:0] value;
    logic [COL_W-1:0]      col;
    logic                  emit;
    logic                  last;
    logic                  has_l;
    logic                  has_r;
    logic                  has_t;
    logic                  has_b;
  } token_t;

  // Frame control seen by the back end.
  typedef struct packed {
    logic       restart;
    logic [1:0] subpass;
  } ctl_t;

  function automatic logic tmpl_hit(logic [2:0] t, logic [7:0] m);
    return ((m & TMPL_ON[t]) == TMPL_ON[t]) && ((m & TMPL_OFF[t]) == 8'd0);
  endfunction

  // A subpass uses templates s, s+1 (mod 4) and s+4.
  function automatic logic subpass_delete(logic [1:0] s, logic [7:0] m);
    logic [1:0] s_next;
    s_next = s + 2'd1;
    return tmpl_hit({1'b0, s}, m) || tmpl_hit({1'b0, s_next}, m) ||
           tmpl_hit({1'b1, s}, m);
  endfunction

endpackage

>>> design/bltsp_front.sv
module bltsp_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bltsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bltsp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             push,
  input  logic                             full,
  input  bltsp_pkg::in_item_t              in_data,
  output logic                             tok_push,
  output bltsp_pkg::token_t                tok,
  output bltsp_pkg::ctl_t                  ctl
);
  import bltsp_pkg::*;

  logic [WDIM_W-1:0] w_r, w_cfg;
  logic [HDIM_W-1:0] h_r, h_cfg;
  logic [1:0]        subpass_r;
  logic [COL_W-1:0]  in_column_r, in_column_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [ROW_W-1:0]  h_row;
  logic              restart, accept, expected, ignored, col_zero, col_wrap;

  assign cfg_ready = 1'b1;
  assign restart   = cfg_valid && (cfg_index == CFG_IDX_WIDTH ||
                     cfg_index == CFG_IDX_HEIGHT || cfg_index == CFG_IDX_SUBPASS);

  // Clamp frame sizes: zero counts as one, large values saturate.
  always_comb begin
    if (cfg_data == '0) begin
      w_cfg = WDIM_W'(1);
      h_cfg = HDIM_W'(1);
    end else begin
      w_cfg = (32'(cfg_data) > MAX_WIDTH) ? WDIM_W'(MAX_WIDTH) : WDIM_W'(cfg_data);
      h_cfg = (32'(cfg_data) > MAX_HEIGHT) ? HDIM_W'(MAX_HEIGHT) : HDIM_W'(cfg_data);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= WDIM_W'(WIDTH_RST);
      h_r       <= HDIM_W'(HEIGHT_RST);
      subpass_r <= 2'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IDX_WIDTH:   w_r       <= w_cfg;
        CFG_IDX_HEIGHT:  h_r       <= h_cfg;
        CFG_IDX_SUBPASS: subpass_r <= cfg_data[1:0];
        default:         ;
      endcase
    end
  end

  assign ctl.restart = restart;
  assign ctl.subpass = subpass_r;

  // Classify the incoming word against the current raster position.
  assign h_row    = ROW_W'(h_r);
  assign accept   = push && !full;
  assign expected = in_row_r < h_row;
  assign ignored  = expected && in_data.op;
  assign col_zero = in_column_r == '0;
  assign col_wrap = (WDIM_W'(in_column_r) + WDIM_W'(1)) >= w_r;

  // The window centre sits one row and one column behind the input.
  always_comb begin
    tok.value = expected ? in_data.pixel[PIXEL_BITS-1:0] : '0;
    tok.col   = in_column_r;
    tok.emit  = (in_row_r >= ROW_W'(2)) || (in_row_r == ROW_W'(1) && !col_zero);
    tok.last  = col_zero && (in_row_r == h_row + ROW_W'(1));
    tok.has_r = !col_zero;
    if (col_zero) begin
      tok.has_l = w_r > WDIM_W'(1);
      tok.has_t = in_row_r >= ROW_W'(3);
      tok.has_b = in_row_r <= h_row;
    end else begin
      tok.has_l = in_column_r > COL_W'(1);
      tok.has_t = in_row_r >= ROW_W'(2);
      tok.has_b = in_row_r < h_row;
    end
  end

  assign tok_push = accept && !ignored;

  // Raster position counters.
  always_comb begin
    in_column_nxt = in_column_r;
    in_row_nxt    = in_row_r;
    if (restart) begin
      in_column_nxt = '0;
      in_row_nxt    = '0;
    end else if (tok_push) begin
      if (tok.last) begin
        in_column_nxt = '0;
        in_row_nxt    = '0;
      end else if (col_wrap) begin
        in_column_nxt = '0;
        in_row_nxt    = in_row_r + ROW_W'(1);
      end else begin
        in_column_nxt = in_column_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_column_r <= '0;
      in_row_r    <= '0;
    end else begin
      in_column_r <= in_column_nxt;
      in_row_r    <= in_row_nxt;
    end
  end

  // A register write starts a new frame.
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> (in_column_r == '0 && in_row_r == '0))
    else $error("frame position not cleared after register write");

  // The row counter never runs past the drain row.
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_row_r <= h_row + ROW_W'(1))
    else $error("row counter beyond end of frame");

endmodule

>>> design/bltsp_tokq.sv
module bltsp_tokq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  bltsp_pkg::token_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output logic              empty,
  output bltsp_pkg::token_t rd_data
);
  import bltsp_pkg::*;

  token_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  assign full    = count_r == Q_CNT_W'(Q_DEPTH);
  assign empty   = count_r == '0;
  assign rd_data = mem_r[rd_ptr_r];

  // Occupancy follows the push and pop strobes.
  always_comb begin
    count_nxt = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // The front end only pushes a word while there is room.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("token queue overflow");

endmodule

>>> design/bltsp_outq.sv
module bltsp_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  bltsp_pkg::out_item_t wr_data,
  output logic                 full,
  input  logic                 rd_en,
  output logic                 empty,
  output bltsp_pkg::out_item_t rd_data
);
  import bltsp_pkg::*;

  out_item_t          mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  assign full    = count_r == Q_CNT_W'(Q_DEPTH);
  assign empty   = count_r == '0;
  assign rd_data = mem_r[rd_ptr_r];

  // Occupancy follows the push and pop strobes.
  always_comb begin
    count_nxt = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // The back end holds its result while this queue is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("result queue overflow");

endmodule

>>> design/bltsp_back.sv
module bltsp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bltsp_pkg::ctl_t      ctl,
  input  bltsp_pkg::token_t    tok,
  input  logic                 tok_empty,
  output logic                 tok_pop,
  input  logic                 res_full,
  output logic                 res_push,
  output bltsp_pkg::out_item_t res
);
  import bltsp_pkg::*;

  // Line buffers indexed by column: pixels of the previous row, and the
  // nonzero bits of the row before that.
  logic [PIXEL_BITS-1:0] pix_mem [MAX_WIDTH];
  logic                  bit_mem [MAX_WIDTH];

  logic                  s1_valid_r;
  token_t                s1_tok_r;
  logic [PIXEL_BITS-1:0] rd_pix_r, p1_r;
  logic                  rd_bit_r;
  logic                  bz1_r, bz2_r, pz2_r, t1_r, t2_r;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic [7:0]            mask;
  logic                  en, adv, bypass, wr_bit, br_nz, del;

  // The pipeline only waits when a result has nowhere to go.
  assign en      = !(s1_valid_r && s1_tok_r.emit && res_full);
  assign tok_pop = en && !tok_empty;
  assign adv     = en && s1_valid_r;
  assign wr_bit  = rd_pix_r != '0;
  // With a one-pixel row the bit written this cycle is the one read now.
  assign bypass  = adv && (s1_tok_r.col == tok.col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= !tok_empty;
    end
  end

  // Stage one: read both line buffers and store the new pixel.
  always_ff @(posedge clk) begin
    if (tok_pop) begin
      s1_tok_r          <= tok;
      rd_pix_r          <= pix_mem[tok.col];
      pix_mem[tok.col]  <= tok.value;
      rd_bit_r          <= bypass ? wr_bit : bit_mem[tok.col];
    end
  end

  // Window history: the two previous words of each of the three rows.
  always_ff @(posedge clk) begin
    if (adv) begin
      bit_mem[s1_tok_r.col] <= wr_bit;
      bz1_r                 <= br_nz;
      bz2_r                 <= bz1_r;
      p1_r                  <= rd_pix_r;
      pz2_r                 <= p1_r != '0;
      t1_r                  <= rd_bit_r;
      t2_r                  <= t1_r;
    end
  end

  // Neighbour mask around the centre, with out-of-image cells as zero.
  assign br_nz = s1_tok_r.value != '0;
  always_comb begin
    mask[0] = s1_tok_r.has_t && s1_tok_r.has_l && t2_r;
    mask[1] = s1_tok_r.has_l && pz2_r;
    mask[2] = s1_tok_r.has_b && s1_tok_r.has_l && bz2_r;
    mask[3] = s1_tok_r.has_b && bz1_r;
    mask[4] = s1_tok_r.has_b && s1_tok_r.has_r && br_nz;
    mask[5] = s1_tok_r.has_r && wr_bit;
    mask[6] = s1_tok_r.has_t && s1_tok_r.has_r && rd_bit_r;
    mask[7] = s1_tok_r.has_t && t1_r;
  end

  assign del     = (p1_r != '0) && subpass_delete(ctl.subpass, mask);
  assign cnt_nxt = (del && cnt_r != COUNT_MAX) ? cnt_r + COUNT_W'(1) : cnt_r;

  // Result word.
  assign res_push           = adv && s1_tok_r.emit;
  assign res.pixel_out      = del ? '0 : 32'(p1_r);
  assign res.was_deleted    = del;
  assign res.frame_last     = s1_tok_r.last;
  assign res.deletion_count = cnt_nxt;

  // Running deletion count, cleared at frame end and on a register write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.restart) begin
      cnt_r <= '0;
    end else if (res_push) begin
      cnt_r <= s1_tok_r.last ? '0 : cnt_nxt;
    end
  end

  a_count_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && s1_tok_r.last) |=> cnt_r == '0)
    else $error("deletion count survived the end of frame");

endmodule

>>> design/binary_line_thinning_subpass.sv
// Latency: a pixel's result appears once width+1 further words have been
// accepted. Flush words ignored at frame start are accepted but never queued.
// Throughput: one word per cycle unless stalled by a full result queue, set by
// the single read and write per cycle of each column line buffer.
// Reset (synchronous, rst_n low): counters, queues and the deletion count clear;
// width and height return to 1024, subpass to 0. Line buffers are not cleared.
module binary_line_thinning_subpass (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bltsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bltsp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             push,
  output logic                             full,
  input  bltsp_pkg::in_item_t              in_data,
  output logic                             empty,
  input  logic                             pop,
  output bltsp_pkg::out_item_t             out_data
);
  import bltsp_pkg::*;

  token_t    fe_tok, be_tok;
  ctl_t      ctl;
  out_item_t res;
  logic      fe_push, tq_full, tq_empty, tq_pop, res_push, oq_full;

  assign full = tq_full;

  // Front end: configuration, raster position and classification.
  bltsp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (tq_full),
    .in_data   (in_data),
    .tok_push  (fe_push),
    .tok       (fe_tok),
    .ctl       (ctl)
  );

  // Decoupling queue between classification and the window.
  bltsp_tokq u_tokq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fe_push),
    .wr_data (fe_tok),
    .full    (tq_full),
    .rd_en   (tq_pop),
    .empty   (tq_empty),
    .rd_data (be_tok)
  );

  // Back end: line buffers, 3x3 window and template decision.
  bltsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .tok       (be_tok),
    .tok_empty (tq_empty),
    .tok_pop   (tq_pop),
    .res_full  (oq_full),
    .res_push  (res_push),
    .res       (res)
  );

  // Result queue.
  bltsp_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (oq_full),
    .rd_en   (pop && !empty),
    .empty   (empty),
    .rd_data (out_data)
  );

endmodule

>>> dv/tb_binary_line_thinning_subpass.sv
module tb_binary_line_thinning_subpass;
  timeunit 1ns;
  timeprecision 1ps;

  import bltsp_pkg::*;

  // Input word kinds.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam int RANDOM_WORDS   = 2000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT    = 4000;
  localparam int PRINT_CAP      = 50;

  // Template pairs: bits that must be set and bits that must be clear.
  localparam bit [7:0] SET_BITS [8] = '{
    8'd40, 8'd10, 8'd130, 8'd160, 8'd42, 8'd138, 8'd162, 8'd168
  };
  localparam bit [7:0] CLEAR_BITS [8] = '{
    8'd131, 8'd224, 8'd56, 8'd14, 8'd128, 8'd32, 8'd8, 8'd2
  };

  // Tracks the thinning subpass on accepted words and checks the results.
  class thinning_scoreboard;
    bit [CFG_DATA_W-1:0] width_reg;
    bit [CFG_DATA_W-1:0] height_reg;
    bit [1:0]            subpass_reg;
    bit [31:0]           line_buf [MAX_WIDTH+1];
    bit                  row_above [MAX_WIDTH];
    int unsigned         col_in, row_in, out_cnt, head;
    bit [COUNT_W-1:0]    del_cnt;
    bit                  diag;
    out_item_t           thinned_q [$];
    int                  errors;

    function new();
      width_reg   = 11'd1024;
      height_reg  = 11'd1024;
      subpass_reg = 2'd0;
      errors      = 0;
      restart();
    endfunction

    function void restart();
      col_in  = 0;
      row_in  = 0;
      out_cnt = 0;
      head    = 0;
      del_cnt = '0;
      diag    = 1'b0;
    endfunction

    function int unsigned clamp_dim(bit [CFG_DATA_W-1:0] v, int unsigned lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
    endfunction

    function int unsigned frame_width();
      return clamp_dim(width_reg, MAX_WIDTH);
    endfunction

    function int unsigned frame_height();
      return clamp_dim(height_reg, MAX_HEIGHT);
    endfunction

    // Any register write starts a new frame.
    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IDX_WIDTH:   width_reg = data;
        CFG_IDX_HEIGHT:  height_reg = data;
        CFG_IDX_SUBPASS: subpass_reg = data[1:0];
        default:         return;
      endcase
      restart();
    endfunction

    function bit [31:0] tap(int unsigned off, int unsigned n);
      int unsigned s;
      s = head + off;
      if (s >= n) s -= n;
      return line_buf[s];
    endfunction

    function bit template_hit(int t, bit [7:0] m);
      return ((m & SET_BITS[t]) == SET_BITS[t]) && ((m & CLEAR_BITS[t]) == 8'd0);
    endfunction

    // Advance the raster by one accepted word and queue the result it releases.
    function void note_word(in_item_t word);
      int unsigned w, h, total, n, c, r;
      bit [31:0]   v, centre;
      bit [7:0]    m;
      bit          l_ok, r_ok, t_ok, b_ok, del, done;
      bit [1:0]    s_next;
      out_item_t   exp_word;
      w     = frame_width();
      h     = frame_height();
      total = w * h;
      n     = w + 1;
      v     = '0;
      done  = 1'b0;
      // Flushes are ignored while pixels are still due; later, every word drains.
      if (row_in < h) begin
        if (word.op == OP_FLUSH) return;
        v = word.pixel;
      end
      if (row_in >= 2 || (row_in == 1 && col_in >= 1)) begin
        if (col_in > 0) begin
          c = col_in - 1;
          r = row_in - 1;
        end else begin
          c = w - 1;
          r = row_in - 2;
        end
        l_ok   = c > 0;
        r_ok   = c + 1 < w;
        t_ok   = r > 0;
        b_ok   = r + 1 < h;
        centre = tap(0, n);
        m      = '0;
        if (l_ok) begin
          m[0] = t_ok && diag;
          m[1] = row_above[c-1];
          m[2] = b_ok && (tap(w - 1, n) != 0);
        end
        if (r_ok) begin
          m[4] = b_ok && (v != 0);
          m[5] = tap(1, n) != 0;
          m[6] = t_ok && row_above[c+1];
        end
        m[3]   = b_ok && (tap(w, n) != 0);
        m[7]   = t_ok && row_above[c];
        s_next = subpass_reg + 2'd1;
        del    = (centre != 0) && (template_hit(subpass_reg, m) ||
                 template_hit(s_next, m) || template_hit(int'(subpass_reg) + 4, m));
        diag         = row_above[c];
        row_above[c] = centre != 0;
        if (del && del_cnt != '1) del_cnt++;
        out_cnt++;
        done = out_cnt >= total;
        exp_word.pixel_out      = del ? '0 : centre;
        exp_word.was_deleted    = del;
        exp_word.frame_last     = done;
        exp_word.deletion_count = del_cnt;
        thinned_q.push_back(exp_word);
      end
      line_buf[head] = v;
      head = (head + 1 >= n) ? 0 : head + 1;
      col_in++;
      if (col_in >= w) begin
        col_in = 0;
        row_in++;
      end
      if (done) restart();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task check_word(out_item_t got);
      out_item_t exp_word;
      if (thinned_q.size() == 0) begin
        report($sformatf("result with nothing expected, pixel_out=%h", got.pixel_out));
        return;
      end
      exp_word = thinned_q.pop_front();
      if (got.pixel_out !== exp_word.pixel_out)
        report($sformatf("pixel_out got %h want %h", got.pixel_out, exp_word.pixel_out));
      if (got.was_deleted !== exp_word.was_deleted)
        report($sformatf("was_deleted got %b want %b", got.was_deleted,
                         exp_word.was_deleted));
      if (got.frame_last !== exp_word.frame_last)
        report($sformatf("frame_last got %b want %b", got.frame_last,
                         exp_word.frame_last));
      if (got.deletion_count !== exp_word.deletion_count)
        report($sformatf("deletion_count got %0d want %0d", got.deletion_count,
                         exp_word.deletion_count));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  push = 1'b0;
  logic                  full;
  in_item_t              in_data = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  out_item_t             out_data;

  thinning_scoreboard sb = new();
  int          tx_idle_pct = 7;
  int          rx_idle_pct = 48;
  bit          rx_hold_req = 1'b0;
  int unsigned rand_words = 0;
  int unsigned quiet_cycles = 0;

  binary_line_thinning_subpass dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sample every handshake at the edge and watch for a stuck block.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (push && !full) sb.note_word(in_data);
      if (pop && !empty) sb.check_word(out_data);
      if ((cfg_valid && cfg_ready) || (push && !full) || (pop && !empty))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        pop <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic logic [31:0] cell_value(bit on);
    logic [31:0] v;
    if (!on) return '0;
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0001;
      default: begin
        v = $urandom();
        return (v == 0) ? 32'h0000_0001 : v;
      end
    endcase
  endfunction

  // Offer one word, with random gaps before it, and wait until it is taken.
  task automatic send_word(input logic op, input logic [31:0] value);
    in_item_t word;
    word.op    = op;
    word.pixel = value;
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= word;
    do @(posedge clk); while (full);
  endtask

  // Stop sending and wait until every expected result has been taken.
  task automatic settle();
    push <= 1'b0;
    while (sb.thinned_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write the selected registers once the block has gone idle.
  task automatic write_regs(input bit [2:0] which, input logic [CFG_DATA_W-1:0] w,
                            input logic [CFG_DATA_W-1:0] h, input logic [1:0] s);
    settle();
    if (which[0]) put_reg(CFG_IDX_WIDTH, w);
    if (which[1]) put_reg(CFG_IDX_HEIGHT, h);
    if (which[2]) put_reg(CFG_IDX_SUBPASS, {9'd0, s});
    cfg_valid <= 1'b0;
  endtask

  // One frame: a blob over random background, stray flushes, then the drain unless cut short.
  task automatic send_frame(input bit broken, input bit counted);
    int unsigned w, h, stop_at, k, x, y, x0, x1, y0, y1, density;
    bit          on;
    w       = sb.frame_width();
    h       = sb.frame_height();
    stop_at = w * h;
    if (broken && stop_at > 1) stop_at = $urandom_range(stop_at - 1, 1);
    x0      = $urandom_range(w - 1);
    x1      = $urandom_range(w - 1, x0);
    y0      = $urandom_range(h - 1);
    y1      = $urandom_range(h - 1, y0);
    density = $urandom_range(60, 5);
    for (k = 0; k < stop_at; k++) begin
      if ($urandom_range(99) < 3) send_word(OP_FLUSH, $urandom());
      x  = k % w;
      y  = k / w;
      on = (x >= x0 && x <= x1 && y >= y0 && y <= y1) ? ($urandom_range(99) < 90) :
                                                        ($urandom_range(99) < density);
      send_word(OP_PIXEL, cell_value(on));
      if (counted) rand_words++;
    end
    if (!broken) begin
      // Pixels past the frame end count as flushes.
      for (k = 0; k <= w; k++) begin
        if ($urandom_range(99) < 20) send_word(OP_PIXEL, $urandom());
        else send_word(OP_FLUSH, $urandom());
        if (counted) rand_words++;
      end
      // A flush at the start of the next frame is dropped.
      if ($urandom_range(99) < 30) send_word(OP_FLUSH, $urandom());
    end
  endtask

  initial begin
    logic [31:0]           seed_img [9];
    int unsigned           frame_no, phase, k;
    bit                    broken, must_write, must_resize;
    bit [2:0]              which;
    logic [CFG_DATA_W-1:0] nw, nh;
    seed_img = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1,
                 32'h5A5A_5A5A, 32'h0, 32'hA5A5_A5A5, 32'h0};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 3x3 frame whose top-left corner is removed by subpass 0.
    write_regs(3'b111, 11'd3, 11'd3, 2'd0);
    for (k = 0; k < 9; k++) begin
      send_word(OP_PIXEL, seed_img[k]);
      if (k == 4) send_word(OP_FLUSH, 32'h0);
    end
    send_word(OP_FLUSH, 32'hFFFF_FFFF);
    send_word(OP_PIXEL, 32'h1234_5678);
    send_word(OP_FLUSH, 32'h0);
    send_word(OP_FLUSH, 32'h0);
    send_word(OP_FLUSH, 32'h0);

    // Directed: a frame cut short, then a register write restarts it.
    write_regs(3'b100, 11'd3, 11'd3, 2'd1);
    for (k = 0; k < 5; k++) send_word(OP_PIXEL, 32'hFFFF_FFFF);
    write_regs(3'b111, 11'd0, 11'd0, 2'd3);

    // Directed: zero sizes read as a single cell.
    send_word(OP_PIXEL, 32'h8000_0000);
    send_word(OP_FLUSH, 32'h0);
    send_word(OP_FLUSH, 32'h0);

    // Random frames over changing sizes and subpasses.
    frame_no    = 0;
    must_write  = 1'b1;
    must_resize = 1'b1;
    while (rand_words < RANDOM_WORDS) begin
      phase = rand_words * 3 / RANDOM_WORDS;
      case (phase)
        0: begin
          tx_idle_pct = 7;
          rx_idle_pct = 48;
        end
        1: begin
          tx_idle_pct = 48;
          rx_idle_pct = 7;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (frame_no == 2) rx_hold_req = 1'b1;
      if (frame_no == 8 || frame_no == 14 || frame_no == 20) begin
        // Largest frames: widest row, saturated width, tallest column.
        case (frame_no)
          8:       write_regs(3'b111, 11'd1024, 11'd1, 2'($urandom_range(3)));
          14:      write_regs(3'b111, 11'd2047, 11'd0, 2'($urandom_range(3)));
          default: write_regs(3'b111, 11'd0, 11'd2047, 2'($urandom_range(3)));
        endcase
        send_frame(1'b0, 1'b0);
        must_write  = 1'b1;
        must_resize = 1'b1;
      end else begin
        if (must_write || $urandom_range(99) < 30) begin
          which = must_resize ? 3'b111 : 3'($urandom_range(7, 1));
          case ($urandom_range(9))
            0:       nw = 11'd0;
            1:       nw = 11'd1;
            2:       nw = 11'd2;
            default: nw = 11'($urandom_range(12, 3));
          endcase
          case ($urandom_range(9))
            0:       nh = 11'd0;
            1:       nh = 11'd1;
            default: nh = 11'($urandom_range(10, 2));
          endcase
          write_regs(which, nw, nh, 2'($urandom_range(3)));
          must_resize = 1'b0;
        end
        broken = ($urandom_range(99) < 10);
        send_frame(broken, 1'b1);
        must_write = broken;
      end
      frame_no++;
    end

    settle();
    if (sb.thinned_q.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.thinned_q.size()));
    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> filelist.f
design/bltsp_pkg.sv
design/bltsp_front.sv
design/bltsp_tokq.sv
design/bltsp_outq.sv
design/bltsp_back.sv
design/binary_line_thinning_subpass.sv
dv/tb_binary_line_thinning_subpass.sv
